/* hw/rtl/grwi_pkg.sv */
// ----------------------------------------------------------------------------
// grwi_pkg
// Types and constants shared by the gyro rotation window integrator.
// ----------------------------------------------------------------------------
package grwi_pkg;

    localparam int TIME_W    = 48;
    localparam int GYRO_W    = 16;
    localparam int INC_W     = 33;
    localparam int SUM_W     = 48;
    localparam int DT_W      = 34;
    localparam int PROD_W    = GYRO_W + DT_W;
    localparam int CFG_W     = 8;
    localparam int MUL_STEPS = DT_W;
    localparam int PRE_DEPTH = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd32;

    localparam logic OP_GYRO  = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [TIME_W-1:0]        time_ms;
        logic signed [GYRO_W-1:0] gyro_z;
        logic                     takeoff_hint;
        logic                     has_landed;
    } in_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] rotation_sum;
        logic [TIME_W-1:0]       stamp_ms;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_INT_A,
        ST_INT_B,
        ST_SWEEP
    } state_t;

endpackage

/* hw/rtl/grwi_mul.sv */
// ----------------------------------------------------------------------------
// grwi_mul
// Bit-serial unsigned multiplier: one multiplier bit per cycle, right shift.
// ----------------------------------------------------------------------------
module grwi_mul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [grwi_pkg::GYRO_W-1:0]           mcand,
    input  logic [grwi_pkg::DT_W-1:0]             mplier,
    output logic                                  done,
    output logic [grwi_pkg::PROD_W-1:0]           product
);

    localparam int CNT_W = $clog2(grwi_pkg::MUL_STEPS);

    logic [grwi_pkg::GYRO_W-1:0] mcand_reg;
    logic [grwi_pkg::GYRO_W-1:0] hi_reg;
    logic [grwi_pkg::DT_W-1:0]   lo_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [grwi_pkg::GYRO_W:0]   step_sum;

    // add the multiplicand into the upper half when the current bit is set
    assign step_sum = {1'b0, hi_reg}
                    + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(grwi_pkg::MUL_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= step_sum[grwi_pkg::GYRO_W:1];
            lo_reg <= {step_sum[0], lo_reg[grwi_pkg::DT_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

/* hw/rtl/grwi_ring.sv */
// ----------------------------------------------------------------------------
// grwi_ring
// Pre-trigger increment ring: one write and one registered read per cycle,
// entries never written read as zero.
// ----------------------------------------------------------------------------
module grwi_ring #(
    parameter int DEPTH = grwi_pkg::PRE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [AW-1:0]                       wr_addr,
    input  logic signed [grwi_pkg::INC_W-1:0]   wr_data,
    input  logic [AW-1:0]                       rd_addr,
    output logic signed [grwi_pkg::INC_W-1:0]   rd_data
);

    logic signed [grwi_pkg::INC_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]                  filled_reg;
    logic signed [grwi_pkg::INC_W-1:0] rd_word_reg;
    logic                              rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                filled_reg[wr_addr] <= 1'b1;
            end
            rd_hit_reg <= filled_reg[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

/* hw/rtl/gyro_rotation_window_integrator_unit.sv */
// ----------------------------------------------------------------------------
// gyro_rotation_window_integrator_unit
// Trapezoidal z-rate angle integrator with a pre-trigger ring and a
// post-landing window.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) carries gyro samples and jump
//   events. out channel (out_valid/out_ready/out_data) carries one word per
//   closed window: the rotation sum in 1/28750 degree and the sample stamp.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes post_landing_samples;
//   it is always ready.
// Timing:
//   a gyro sample passes from accept to the next ready through the bit-serial
//   multiplier (one elapsed-time bit per cycle), a saturation step and the two
//   trapezoid states ST_INT_A and ST_INT_B. The result is registered onto
//   out_valid and out_data in ST_INT_B of the closing sample.
//   a taken takeoff hint walks the ring one entry per cycle through its
//   read port. Other jump events are handled in ST_IDLE and keep in_ready high.
// Reset:
//   resets control state, not stamp/sign/increment/output data; ring entries
//   read as zero until written, with no clearing pass, and cfg_reg returns to 32.
// Stall:
//   the output word is held in a register; new items are taken while it
//   waits, and only a second result waits on out_ready.
// ----------------------------------------------------------------------------
module gyro_rotation_window_integrator_unit #(
    parameter int PRE_DEPTH = grwi_pkg::PRE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  grwi_pkg::in_word_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output grwi_pkg::out_word_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [grwi_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW = $clog2(PRE_DEPTH);
    localparam int CW = $clog2(PRE_DEPTH + 1);

    grwi_pkg::state_t                   state_reg, state_next;
    logic                               airborne_reg, airborne_next;
    logic [grwi_pkg::CFG_W-1:0]         after_reg, after_next;
    logic [grwi_pkg::CFG_W-1:0]         cfg_reg;
    logic [grwi_pkg::TIME_W-1:0]        prev_time_reg, prev_time_next;
    logic [grwi_pkg::TIME_W-1:0]        stamp_reg, stamp_next;
    logic                               neg_reg, neg_next;
    logic signed [grwi_pkg::INC_W-1:0]  prev_inc_reg, prev_inc_next;
    logic signed [grwi_pkg::INC_W-1:0]  inc_reg, inc_next;
    logic signed [grwi_pkg::SUM_W-1:0]  angle_reg, angle_next;
    logic [AW-1:0]                      ptr_reg, ptr_next;
    logic [CW-1:0]                      idx_reg, idx_next;
    logic                               rd_pend_reg, rd_pend_next;
    logic                               out_valid_reg, out_valid_next;
    grwi_pkg::out_word_t                out_data_reg, out_data_next;

    logic                               accept;
    logic [grwi_pkg::TIME_W-1:0]        diff;
    logic                               diff_ok;
    logic [grwi_pkg::DT_W-1:0]          dt;
    logic [grwi_pkg::GYRO_W-1:0]        mag;
    logic                               mul_start;
    logic                               mul_done;
    logic [grwi_pkg::PROD_W-1:0]        product;
    logic                               ring_wr;
    logic signed [grwi_pkg::INC_W-1:0]  ring_val;
    logic signed [grwi_pkg::INC_W-1:0]  step_inc;
    logic signed [grwi_pkg::SUM_W-1:0]  step_sum;

    function automatic logic signed [grwi_pkg::SUM_W-1:0] trap_add(
        input logic signed [grwi_pkg::SUM_W-1:0] a,
        input logic signed [grwi_pkg::INC_W-1:0] b,
        input logic signed [grwi_pkg::INC_W-1:0] c
    );
        logic signed [grwi_pkg::SUM_W+1:0] s;
        s = (grwi_pkg::SUM_W+2)'(a) + (grwi_pkg::SUM_W+2)'(b)
          + (grwi_pkg::SUM_W+2)'(c);
        if (s[grwi_pkg::SUM_W+1:grwi_pkg::SUM_W-1] == 3'b000
            || s[grwi_pkg::SUM_W+1:grwi_pkg::SUM_W-1] == 3'b111)
        begin
            return s[grwi_pkg::SUM_W-1:0];
        end
        else if (s[grwi_pkg::SUM_W+1])
        begin
            return {1'b1, {(grwi_pkg::SUM_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(grwi_pkg::SUM_W-1){1'b1}}};
        end
    endfunction

    // signed increment from magnitude and sign, clipped to 33 bits
    function automatic logic signed [grwi_pkg::INC_W-1:0] sat_inc(
        input logic                        neg,
        input logic [grwi_pkg::PROD_W-1:0] p
    );
        logic [grwi_pkg::INC_W-1:0] low;
        low = p[grwi_pkg::INC_W-1:0];
        if (!neg)
        begin
            if (p[grwi_pkg::PROD_W-1:grwi_pkg::INC_W-1] != '0)
            begin
                return {1'b0, {(grwi_pkg::INC_W-1){1'b1}}};
            end
            return {1'b0, low[grwi_pkg::INC_W-2:0]};
        end
        else
        begin
            if (p[grwi_pkg::PROD_W-1:grwi_pkg::INC_W] != '0
                || (low[grwi_pkg::INC_W-1] && low[grwi_pkg::INC_W-2:0] != '0))
            begin
                return {1'b1, {(grwi_pkg::INC_W-1){1'b0}}};
            end
            return ~low + 1'b1;
        end
    endfunction

    assign in_ready  = (state_reg == grwi_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // elapsed time, zero without a previous stamp or a later time, clipped to 2^33
    assign diff    = in_data.time_ms - prev_time_reg;
    assign diff_ok = (prev_time_reg != '0) && (in_data.time_ms > prev_time_reg);

    always_comb
    begin
        if (!diff_ok)
        begin
            dt = '0;
        end
        else if (diff[grwi_pkg::TIME_W-1:grwi_pkg::DT_W] != '0
                 || (diff[grwi_pkg::DT_W-1] && diff[grwi_pkg::DT_W-2:0] != '0))
        begin
            dt = {1'b1, {(grwi_pkg::DT_W-1){1'b0}}};
        end
        else
        begin
            dt = diff[grwi_pkg::DT_W-1:0];
        end
    end

    assign mag = in_data.gyro_z[grwi_pkg::GYRO_W-1]
               ? (~in_data.gyro_z + 1'b1) : in_data.gyro_z;

    assign step_inc = (state_reg == grwi_pkg::ST_SWEEP) ? ring_val : inc_reg;
    assign step_sum = trap_add(angle_reg, step_inc, prev_inc_reg);

    grwi_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mag),
        .mplier  (dt),
        .done    (mul_done),
        .product (product)
    );

    grwi_ring #(
        .DEPTH (PRE_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ring_wr),
        .wr_addr (ptr_next),
        .wr_data (inc_reg),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ring_val)
    );

    always_comb
    begin
        state_next     = state_reg;
        airborne_next  = airborne_reg;
        after_next     = after_reg;
        prev_time_next = prev_time_reg;
        stamp_next     = stamp_reg;
        neg_next       = neg_reg;
        prev_inc_next  = prev_inc_reg;
        inc_next       = inc_reg;
        angle_next     = angle_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        rd_pend_next   = rd_pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_start      = 1'b0;
        ring_wr        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            grwi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.op == grwi_pkg::OP_GYRO)
                    begin
                        prev_time_next = in_data.time_ms;
                        stamp_next     = in_data.time_ms;
                        neg_next       = in_data.gyro_z[grwi_pkg::GYRO_W-1];
                        mul_start      = 1'b1;
                        state_next     = grwi_pkg::ST_MUL;
                    end
                    else if (in_data.takeoff_hint && after_reg == '0)
                    begin
                        airborne_next  = 1'b1;
                        angle_next     = '0;
                        prev_time_next = in_data.time_ms;
                        idx_next       = '0;
                        rd_pend_next   = 1'b0;
                        state_next     = grwi_pkg::ST_SWEEP;
                    end
                    else if (in_data.has_landed)
                    begin
                        airborne_next = 1'b0;
                        after_next    = cfg_reg;
                    end
                end
            end
            grwi_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    inc_next   = sat_inc(neg_reg, product);
                    state_next = grwi_pkg::ST_INT_A;
                end
            end
            grwi_pkg::ST_INT_A:
            begin
                if (airborne_reg)
                begin
                    angle_next    = step_sum;
                    prev_inc_next = inc_reg;
                end
                state_next = grwi_pkg::ST_INT_B;
            end
            grwi_pkg::ST_INT_B:
            begin
                if (after_reg != '0)
                begin
                    // closing sample waits only if the last word is still held
                    if (!(after_reg == 1'b1 && out_valid_reg && !out_ready))
                    begin
                        angle_next    = step_sum;
                        prev_inc_next = inc_reg;
                        after_next    = after_reg - 1'b1;
                        if (after_reg == 1'b1)
                        begin
                            out_valid_next              = 1'b1;
                            out_data_next.rotation_sum  = step_sum;
                            out_data_next.stamp_ms      = stamp_reg;
                        end
                        state_next = grwi_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    ptr_next   = (ptr_reg == AW'(PRE_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                    ring_wr    = 1'b1;
                    state_next = grwi_pkg::ST_IDLE;
                end
            end
            grwi_pkg::ST_SWEEP:
            begin
                // read issued in the cycle before its trapezoid step
                if (rd_pend_reg)
                begin
                    angle_next    = step_sum;
                    prev_inc_next = ring_val;
                end
                if (idx_reg == CW'(PRE_DEPTH))
                begin
                    rd_pend_next = 1'b0;
                    state_next   = grwi_pkg::ST_IDLE;
                end
                else
                begin
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = grwi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= grwi_pkg::ST_IDLE;
            airborne_reg  <= 1'b0;
            after_reg     <= '0;
            cfg_reg       <= grwi_pkg::CFG_RESET;
            prev_time_reg <= '0;
            prev_inc_reg  <= '0;
            angle_reg     <= '0;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            airborne_reg  <= airborne_next;
            after_reg     <= after_next;
            prev_time_reg <= prev_time_next;
            prev_inc_reg  <= prev_inc_next;
            angle_reg     <= angle_next;
            ptr_reg       <= ptr_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg    <= stamp_next;
        neg_reg      <= neg_next;
        inc_reg      <= inc_next;
        out_data_reg <= out_data_next;
    end

endmodule
